[rtl/core/fcu_pkg.sv]
// Shared types, constants and tables for the fly camera update block.
package fcu_pkg;

   // Width of the shared serial multiplier operands (signed).
   localparam int MUL_W  = 34;
   localparam int MUL_CW = 6;
   // Root extractor: radicand width and root width.
   localparam int SQ_W   = 64;
   localparam int RT_W   = 32;
   // Divider: dividend and divisor widths.
   localparam int DV_NW  = 44;
   localparam int DV_DW  = 32;
   // Rotation unit: datapath width and step count.
   localparam int CO_W     = 34;
   localparam int CO_STEPS = 16;

   localparam logic signed [CO_W-1:0] CO_GAIN    = 34'sd652032874;
   localparam logic signed [CO_W-1:0] CO_QUARTER = 34'sd1073741824;
   localparam logic signed [CO_W-1:0] CO_HALF    = 34'sd2147483648;

   localparam logic signed [15:0] FRONT_ONE = 16'sd16384;

   // Configuration register indexes.
   localparam logic [2:0] CSR_START_POS_X   = 3'd0;
   localparam logic [2:0] CSR_START_POS_Y   = 3'd1;
   localparam logic [2:0] CSR_START_POS_Z   = 3'd2;
   localparam logic [2:0] CSR_START_FRONT_X = 3'd3;
   localparam logic [2:0] CSR_START_FRONT_Y = 3'd4;
   localparam logic [2:0] CSR_START_FRONT_Z = 3'd5;
   localparam logic [2:0] CSR_LOOK_SENS     = 3'd6;
   localparam logic [2:0] CSR_START_YAW     = 3'd7;

   typedef enum logic [4:0] {
      S_IDLE, S_MF0, S_MF1, S_MF2, S_MVF, S_MVB, S_L2X, S_L2Z, S_SQ,
      S_DVX, S_DVZ, S_MSX, S_MSZ, S_MVR, S_MVL, S_MYAW, S_MPIT,
      S_CYAW, S_CPIT, S_MFX, S_MFZ, S_FIN
   } state_type;

   // Arctangent of 2^-i as a binary angle (full turn 2^32).
   function automatic logic [31:0] atan_tab(input logic [3:0] i);
      logic [31:0] v;
      case (i)
         4'd0:    v = 32'h20000000;
         4'd1:    v = 32'h12E4051E;
         4'd2:    v = 32'h09FB385B;
         4'd3:    v = 32'h051111D4;
         4'd4:    v = 32'h028B0D43;
         4'd5:    v = 32'h0145D7E1;
         4'd6:    v = 32'h00A2F61E;
         4'd7:    v = 32'h00517C55;
         4'd8:    v = 32'h0028BE53;
         4'd9:    v = 32'h00145F2F;
         4'd10:   v = 32'h000A2F98;
         4'd11:   v = 32'h000517CC;
         4'd12:   v = 32'h00028BE6;
         4'd13:   v = 32'h000145F3;
         4'd14:   v = 32'h0000A2FA;
         4'd15:   v = 32'h0000517D;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

[rtl/core/fcu_mul.sv]
// Serial shift-add signed multiplier, one multiplier bit per cycle.
module fcu_mul (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [fcu_pkg::MUL_W-1:0]      opa,
   input  logic signed [fcu_pkg::MUL_W-1:0]      opb,
   output logic                                  done,
   output logic signed [2*fcu_pkg::MUL_W:0]      prod
);
   localparam int W = fcu_pkg::MUL_W;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [fcu_pkg::MUL_CW-1:0]  cnt_ff, cnt_in;
   logic [W-1:0]                am_ff, am_in;
   logic [W-1:0]                hi_ff, hi_in;
   logic [W-1:0]                lo_ff, lo_in;
   logic                        neg_ff, neg_in;
   logic [W:0]                  sum;
   logic [2*W:0]                mag;

   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, am_ff} : '0);
   assign mag = {1'b0, hi_ff, lo_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      am_in   = am_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = fcu_pkg::MUL_CW'(W);
         am_in   = opa[W-1] ? W'(-opa) : W'(opa);
         lo_in   = opb[W-1] ? W'(-opb) : W'(opb);
         hi_in   = '0;
         neg_in  = opa[W-1] ^ opb[W-1];
      end else if (busy_ff) begin
         // add, then shift the partial product right by one
         hi_in  = sum[W:1];
         lo_in  = {sum[0], lo_ff[W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == fcu_pkg::MUL_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      am_ff  <= am_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign prod = neg_ff ? $signed(-mag) : $signed(mag);

endmodule

[rtl/core/fcu_sqrt.sv]
// Integer square root, two radicand bits per cycle.
module fcu_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fcu_pkg::SQ_W-1:0]      radicand,
   output logic                          done,
   output logic [fcu_pkg::RT_W-1:0]      root
);
   localparam int SW = fcu_pkg::SQ_W;
   localparam int RW = fcu_pkg::RT_W;

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [4:0]      cnt_ff, cnt_in;
   logic [SW-1:0]   vr_ff, vr_in;
   logic [RW+1:0]   rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [RW+3:0]   r2;
   logic [RW+3:0]   trial;

   assign r2    = {rem_ff, vr_ff[SW-1:SW-2]};
   assign trial = {2'b00, root_ff, 2'b01};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      vr_in   = vr_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd31;
         vr_in   = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         vr_in = {vr_ff[SW-3:0], 2'b00};
         if (r2 >= trial) begin
            rem_in  = (RW+2)'(r2 - trial);
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = (RW+2)'(r2);
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      vr_ff   <= vr_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[rtl/core/fcu_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module fcu_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fcu_pkg::DV_NW-1:0]     numer,
   input  logic [fcu_pkg::DV_DW-1:0]     denom,
   output logic                          done,
   output logic [fcu_pkg::DV_NW-1:0]     quo
);
   localparam int NW = fcu_pkg::DV_NW;
   localparam int DW = fcu_pkg::DV_DW;

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [5:0]      cnt_ff, cnt_in;
   logic [NW-1:0]   nr_ff, nr_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   den_ff, den_in;
   logic [DW:0]     r;
   logic            ge;

   assign r  = {rem_ff, nr_ff[NW-1]};
   assign ge = r >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      nr_in   = nr_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(NW - 1);
         nr_in   = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = ge ? DW'(r - {1'b0, den_ff}) : DW'(r);
         nr_in  = {nr_ff[NW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      nr_ff  <= nr_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = nr_ff;

endmodule

[rtl/core/fcu_cordic.sv]
// Iterative rotation unit: cos and sin of a binary angle, one step per cycle.
module fcu_cordic (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [31:0]                           angle,
   output logic                                  done,
   output logic signed [fcu_pkg::CO_W-1:0]       cos_q,
   output logic signed [fcu_pkg::CO_W-1:0]       sin_q
);
   localparam int W = fcu_pkg::CO_W;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [3:0]           i_ff, i_in;
   logic                 flip_ff, flip_in;
   logic signed [W-1:0]  x_ff, x_in;
   logic signed [W-1:0]  y_ff, y_in;
   logic signed [W-1:0]  z_ff, z_in;
   logic signed [W-1:0]  zs;
   logic signed [W-1:0]  xs;
   logic signed [W-1:0]  ys;
   logic signed [W-1:0]  at;

   assign zs = $signed({{(W-32){angle[31]}}, angle});
   assign xs = x_ff >>> i_ff;
   assign ys = y_ff >>> i_ff;
   assign at = $signed({{(W-32){1'b0}}, fcu_pkg::atan_tab(i_ff)});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      i_in    = i_ff;
      flip_in = flip_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         i_in    = '0;
         x_in    = fcu_pkg::CO_GAIN;
         y_in    = '0;
         // fold angles outside the right half plane by half a turn
         if (zs >= fcu_pkg::CO_QUARTER || zs < -fcu_pkg::CO_QUARTER) begin
            flip_in = 1'b1;
            z_in    = zs[W-1] ? zs + fcu_pkg::CO_HALF : zs - fcu_pkg::CO_HALF;
         end else begin
            flip_in = 1'b0;
            z_in    = zs;
         end
      end else if (busy_ff) begin
         if (!z_ff[W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == 4'(fcu_pkg::CO_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         i_ff    <= i_in;
      end
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign done  = done_ff;
   assign cos_q = flip_ff ? -x_ff : x_ff;
   assign sin_q = flip_ff ? -y_ff : y_ff;

endmodule

[rtl/core/fly_camera_update.sv]
// Top level of the fly camera update block: sequencer, state and ports.
// req_* carries one transaction per frame; tuser[0] is cmd: 0 steps the camera
//   (move keys, mouse offsets, step speed), 1 reloads position, front and yaw
//   from the start registers and clears pitch.
// rsp_* returns one transaction per request: position (Q16.16), front (Q1.14).
// csr_* writes a start register or the look sensitivity; write only while idle.
// A frame step runs through one shared serial multiplier (eleven products with
//   the strafe), a root extractor, a divider (one run per strafe component) and
//   a rotation unit (one run per angle); the strafe is skipped when the old
//   front is vertical. The multiplier takes most of a step's time. A reload
//   loads the camera at acceptance and presents its result from S_FIN once the
//   output register is free.
// Throughput: req_tready is high only while the sequencer is idle, so one frame
//   is in work at a time; no new request is taken before the last result has
//   entered the output register.
// Reset: synchronous; loads the start registers with their defaults and the
//   camera with position 0, front (0,0,-1), yaw -90 degrees, pitch 0.
// Stall: a finished result sits in the output register; the next frame is
//   accepted and computed meanwhile, and it waits at its end until rsp_tready
//   frees the register.
module fly_camera_update (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [0] move_forward, [1] move_back, [2] move_left, [3] move_right,
   // [19:4] yaw_offset, [35:20] pitch_offset, [51:36] step_speed
   input  logic [55:0]   req_tdata,
   // [0] cmd
   input  logic [0:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z,
   // [111:96] front_x, [127:112] front_y, [143:128] front_z
   output logic [143:0]  rsp_tdata,
   input  logic          csr_we,
   input  logic [2:0]    csr_addr,
   input  logic [31:0]   csr_wdata
);
   localparam int W = fcu_pkg::MUL_W;

   fcu_pkg::state_type  state_ff, state_in;
   logic                busy_ff, busy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [143:0]        rsp_data_ff, rsp_data_in;

   // start registers
   logic signed [31:0]  spos_ff [3];
   logic signed [31:0]  spos_in [3];
   logic signed [15:0]  sfront_ff [3];
   logic signed [15:0]  sfront_in [3];
   logic [23:0]         sens_ff, sens_in;
   logic [31:0]         syaw_ff, syaw_in;

   // camera state
   logic signed [31:0]  pos_ff [3];
   logic signed [31:0]  pos_in [3];
   logic signed [15:0]  front_ff [3];
   logic signed [15:0]  front_in [3];
   logic [31:0]         yaw_ff, yaw_in;
   logic [31:0]         pitch_ff, pitch_in;

   // held request fields
   logic                fwd_ff, fwd_in, back_ff, back_in;
   logic                left_ff, left_in, right_ff, right_in;
   logic signed [15:0]  yoff_ff, yoff_in, poff_ff, poff_in, spd_ff, spd_in;

   // intermediate results
   logic signed [W-1:0] df_ff [3];
   logic signed [W-1:0] df_in [3];
   logic signed [W-1:0] dsx_ff, dsx_in, dsz_ff, dsz_in;
   logic [31:0]         l2_ff, l2_in;
   logic [31:0]         len_ff, len_in;
   logic signed [17:0]  svx_ff, svx_in, svz_ff, svz_in;
   logic signed [W-1:0] cy_ff, cy_in, sy_ff, sy_in, cp_ff, cp_in;

   // unit handshakes
   logic                is_mul, is_div, is_co;
   logic                mul_start, sq_start, dv_start, co_start;
   logic                mul_done, sq_done, dv_done, co_done, unit_done, in_unit;
   logic signed [W-1:0] mul_a, mul_b;
   logic signed [2*W:0] mul_p;
   logic [31:0]         sq_root;
   logic [fcu_pkg::DV_NW-1:0] dv_numer, dv_q;
   logic [15:0]         dv_mag;
   logic                dv_neg;
   logic [31:0]         co_angle;
   logic signed [W-1:0] co_cos, co_sin;
   logic signed [2*W:0] rnd_p;
   logic signed [W-1:0] rnd_s;
   logic signed [17:0]  sv_q;
   logic [31:0]         l2_sum;

   // Add or subtract a step and saturate to the 32-bit signed range.
   function automatic logic signed [31:0] sat_step(input logic signed [31:0] p,
                                                   input logic signed [W-1:0] d,
                                                   input logic sub);
      logic signed [W:0] s;
      s = sub ? (W+1)'(p) - (W+1)'(d) : (W+1)'(p) + (W+1)'(d);
      if (s > (W+1)'(32'sh7FFFFFFF))
         return 32'sh7FFFFFFF;
      else if (s < -(W+1)'(33'sh080000000))
         return 32'sh80000000;
      else
         return s[31:0];
   endfunction

   // Clamp a rounded component to [-1, 1] in Q1.14.
   function automatic logic signed [15:0] clamp_front(input logic signed [22:0] v);
      if (v > 23'(fcu_pkg::FRONT_ONE))
         return fcu_pkg::FRONT_ONE;
      else if (v < -23'(fcu_pkg::FRONT_ONE))
         return -fcu_pkg::FRONT_ONE;
      else
         return v[15:0];
   endfunction

   assign is_mul = state_ff inside {fcu_pkg::S_MF0, fcu_pkg::S_MF1, fcu_pkg::S_MF2,
                                    fcu_pkg::S_L2X, fcu_pkg::S_L2Z, fcu_pkg::S_MSX,
                                    fcu_pkg::S_MSZ, fcu_pkg::S_MYAW, fcu_pkg::S_MPIT,
                                    fcu_pkg::S_MFX, fcu_pkg::S_MFZ};
   assign is_div = state_ff inside {fcu_pkg::S_DVX, fcu_pkg::S_DVZ};
   assign is_co  = state_ff inside {fcu_pkg::S_CYAW, fcu_pkg::S_CPIT};
   assign in_unit = is_mul || is_div || is_co || (state_ff == fcu_pkg::S_SQ);

   assign mul_start = is_mul && !busy_ff;
   assign sq_start  = (state_ff == fcu_pkg::S_SQ) && !busy_ff;
   assign dv_start  = is_div && !busy_ff;
   assign co_start  = is_co && !busy_ff;

   assign unit_done = is_mul ? mul_done :
                      is_div ? dv_done :
                      is_co  ? co_done :
                      (state_ff == fcu_pkg::S_SQ) ? sq_done : 1'b0;

   // operand selection for the shared multiplier
   always_comb begin
      case (state_ff)
         fcu_pkg::S_MF0: begin mul_a = W'(front_ff[0]); mul_b = W'(spd_ff); end
         fcu_pkg::S_MF1: begin mul_a = W'(front_ff[1]); mul_b = W'(spd_ff); end
         fcu_pkg::S_MF2: begin mul_a = W'(front_ff[2]); mul_b = W'(spd_ff); end
         fcu_pkg::S_L2X: begin mul_a = W'(front_ff[0]); mul_b = W'(front_ff[0]); end
         fcu_pkg::S_L2Z: begin mul_a = W'(front_ff[2]); mul_b = W'(front_ff[2]); end
         fcu_pkg::S_MSX: begin mul_a = W'(svx_ff); mul_b = W'(spd_ff); end
         fcu_pkg::S_MSZ: begin mul_a = W'(svz_ff); mul_b = W'(spd_ff); end
         fcu_pkg::S_MYAW: begin
            mul_a = $signed({{(W-24){1'b0}}, sens_ff});
            mul_b = W'(yoff_ff);
         end
         fcu_pkg::S_MPIT: begin
            mul_a = $signed({{(W-24){1'b0}}, sens_ff});
            mul_b = W'(poff_ff);
         end
         fcu_pkg::S_MFX: begin mul_a = cy_ff; mul_b = cp_ff; end
         fcu_pkg::S_MFZ: begin mul_a = sy_ff; mul_b = cp_ff; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // strafe component: c = -fz for x, c = fx for z
   always_comb begin
      if (state_ff == fcu_pkg::S_DVZ) begin
         dv_neg = front_ff[0][15];
         dv_mag = front_ff[0][15] ? 16'(-front_ff[0]) : 16'(front_ff[0]);
      end else begin
         dv_neg = !front_ff[2][15] && (front_ff[2] != 16'sd0);
         dv_mag = front_ff[2][15] ? 16'(-front_ff[2]) : 16'(front_ff[2]);
      end
   end
   assign dv_numer = {dv_mag, 28'd0} + fcu_pkg::DV_NW'(len_ff >> 1);
   assign sv_q     = dv_neg ? -$signed(dv_q[17:0]) : $signed(dv_q[17:0]);

   assign co_angle = (state_ff == fcu_pkg::S_CPIT) ? pitch_ff : yaw_ff;
   assign rnd_p    = mul_p + (2*W+1)'(64'sd35184372088832);
   assign rnd_s    = co_sin + W'(32'sd32768);
   assign l2_sum   = l2_ff + mul_p[31:0];

   fcu_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .opa (mul_a), .opb (mul_b), .done (mul_done), .prod (mul_p)
   );

   fcu_sqrt u_sqrt (
      .clock (clock), .reset (reset), .start (sq_start),
      .radicand ({4'd0, l2_ff, 28'd0}), .done (sq_done), .root (sq_root)
   );

   fcu_div u_div (
      .clock (clock), .reset (reset), .start (dv_start),
      .numer (dv_numer), .denom (len_ff), .done (dv_done), .quo (dv_q)
   );

   fcu_cordic u_cordic (
      .clock (clock), .reset (reset), .start (co_start),
      .angle (co_angle), .done (co_done), .cos_q (co_cos), .sin_q (co_sin)
   );

   // sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      busy_in      = in_unit ? (busy_ff ? !unit_done : 1'b1) : 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      spos_in      = spos_ff;
      sfront_in    = sfront_ff;
      sens_in      = sens_ff;
      syaw_in      = syaw_ff;
      pos_in       = pos_ff;
      front_in     = front_ff;
      yaw_in       = yaw_ff;
      pitch_in     = pitch_ff;
      fwd_in       = fwd_ff;
      back_in      = back_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      yoff_in      = yoff_ff;
      poff_in      = poff_ff;
      spd_in       = spd_ff;
      df_in        = df_ff;
      dsx_in       = dsx_ff;
      dsz_in       = dsz_ff;
      l2_in        = l2_ff;
      len_in       = len_ff;
      svx_in       = svx_ff;
      svz_in       = svz_ff;
      cy_in        = cy_ff;
      sy_in        = sy_ff;
      cp_in        = cp_ff;
      req_tready   = (state_ff == fcu_pkg::S_IDLE);

      if (csr_we) begin
         case (csr_addr)
            fcu_pkg::CSR_START_POS_X:   spos_in[0]   = csr_wdata;
            fcu_pkg::CSR_START_POS_Y:   spos_in[1]   = csr_wdata;
            fcu_pkg::CSR_START_POS_Z:   spos_in[2]   = csr_wdata;
            fcu_pkg::CSR_START_FRONT_X: sfront_in[0] = csr_wdata[15:0];
            fcu_pkg::CSR_START_FRONT_Y: sfront_in[1] = csr_wdata[15:0];
            fcu_pkg::CSR_START_FRONT_Z: sfront_in[2] = csr_wdata[15:0];
            fcu_pkg::CSR_LOOK_SENS:     sens_in      = csr_wdata[23:0];
            fcu_pkg::CSR_START_YAW:     syaw_in      = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         fcu_pkg::S_IDLE: begin
            if (req_tvalid) begin
               fwd_in   = req_tdata[0];
               back_in  = req_tdata[1];
               left_in  = req_tdata[2];
               right_in = req_tdata[3];
               yoff_in  = req_tdata[19:4];
               poff_in  = req_tdata[35:20];
               spd_in   = req_tdata[51:36];
               if (req_tuser[0]) begin
                  // reload the camera from the start registers
                  pos_in   = spos_ff;
                  front_in = sfront_ff;
                  yaw_in   = syaw_ff;
                  pitch_in = '0;
                  state_in = fcu_pkg::S_FIN;
               end else begin
                  state_in = fcu_pkg::S_MF0;
               end
            end
         end
         fcu_pkg::S_MF0: if (unit_done) begin
            df_in[0] = mul_p[W+5:6];
            state_in = fcu_pkg::S_MF1;
         end
         fcu_pkg::S_MF1: if (unit_done) begin
            df_in[1] = mul_p[W+5:6];
            state_in = fcu_pkg::S_MF2;
         end
         fcu_pkg::S_MF2: if (unit_done) begin
            df_in[2] = mul_p[W+5:6];
            state_in = fcu_pkg::S_MVF;
         end
         fcu_pkg::S_MVF: begin
            if (fwd_ff) begin
               for (int k = 0; k < 3; k++)
                  pos_in[k] = sat_step(pos_ff[k], df_ff[k], 1'b0);
            end
            state_in = fcu_pkg::S_MVB;
         end
         fcu_pkg::S_MVB: begin
            if (back_ff) begin
               for (int k = 0; k < 3; k++)
                  pos_in[k] = sat_step(pos_ff[k], df_ff[k], 1'b1);
            end
            state_in = fcu_pkg::S_L2X;
         end
         fcu_pkg::S_L2X: if (unit_done) begin
            l2_in    = mul_p[31:0];
            state_in = fcu_pkg::S_L2Z;
         end
         fcu_pkg::S_L2Z: if (unit_done) begin
            l2_in = l2_sum;
            // vertical front: no strafe direction, skip both strafe keys
            state_in = (l2_sum == 32'd0) ? fcu_pkg::S_MYAW : fcu_pkg::S_SQ;
         end
         fcu_pkg::S_SQ: if (unit_done) begin
            len_in   = sq_root;
            state_in = fcu_pkg::S_DVX;
         end
         fcu_pkg::S_DVX: if (unit_done) begin
            svx_in   = sv_q;
            state_in = fcu_pkg::S_DVZ;
         end
         fcu_pkg::S_DVZ: if (unit_done) begin
            svz_in   = sv_q;
            state_in = fcu_pkg::S_MSX;
         end
         fcu_pkg::S_MSX: if (unit_done) begin
            dsx_in   = mul_p[W+5:6];
            state_in = fcu_pkg::S_MSZ;
         end
         fcu_pkg::S_MSZ: if (unit_done) begin
            dsz_in   = mul_p[W+5:6];
            state_in = fcu_pkg::S_MVR;
         end
         fcu_pkg::S_MVR: begin
            if (right_ff) begin
               pos_in[0] = sat_step(pos_ff[0], dsx_ff, 1'b0);
               pos_in[2] = sat_step(pos_ff[2], dsz_ff, 1'b0);
            end
            state_in = fcu_pkg::S_MVL;
         end
         fcu_pkg::S_MVL: begin
            if (left_ff) begin
               pos_in[0] = sat_step(pos_ff[0], dsx_ff, 1'b1);
               pos_in[2] = sat_step(pos_ff[2], dsz_ff, 1'b1);
            end
            state_in = fcu_pkg::S_MYAW;
         end
         fcu_pkg::S_MYAW: if (unit_done) begin
            yaw_in   = yaw_ff + mul_p[31:0];
            state_in = fcu_pkg::S_MPIT;
         end
         fcu_pkg::S_MPIT: if (unit_done) begin
            pitch_in = pitch_ff + mul_p[31:0];
            state_in = fcu_pkg::S_CYAW;
         end
         fcu_pkg::S_CYAW: if (unit_done) begin
            cy_in    = co_cos;
            sy_in    = co_sin;
            state_in = fcu_pkg::S_CPIT;
         end
         fcu_pkg::S_CPIT: if (unit_done) begin
            cp_in       = co_cos;
            front_in[1] = clamp_front(23'($signed(rnd_s[W-1:16])));
            state_in    = fcu_pkg::S_MFX;
         end
         fcu_pkg::S_MFX: if (unit_done) begin
            front_in[0] = clamp_front($signed(rnd_p[2*W:46]));
            state_in    = fcu_pkg::S_MFZ;
         end
         fcu_pkg::S_MFZ: if (unit_done) begin
            front_in[2] = clamp_front($signed(rnd_p[2*W:46]));
            state_in    = fcu_pkg::S_FIN;
         end
         fcu_pkg::S_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {front_ff[2], front_ff[1], front_ff[0],
                               pos_ff[2], pos_ff[1], pos_ff[0]};
               state_in     = fcu_pkg::S_IDLE;
            end
         end
         default: state_in = fcu_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcu_pkg::S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         spos_ff      <= '{32'sd0, 32'sd0, 32'sd0};
         sfront_ff    <= '{16'sd0, 16'sd0, -16'sd16384};
         sens_ff      <= 24'd1193046;
         syaw_ff      <= 32'd3221225472;
         pos_ff       <= '{32'sd0, 32'sd0, 32'sd0};
         front_ff     <= '{16'sd0, 16'sd0, -16'sd16384};
         yaw_ff       <= 32'd3221225472;
         pitch_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         spos_ff      <= spos_in;
         sfront_ff    <= sfront_in;
         sens_ff      <= sens_in;
         syaw_ff      <= syaw_in;
         pos_ff       <= pos_in;
         front_ff     <= front_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
      end
      rsp_data_ff <= rsp_data_in;
      fwd_ff      <= fwd_in;
      back_ff     <= back_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      yoff_ff     <= yoff_in;
      poff_ff     <= poff_in;
      spd_ff      <= spd_in;
      df_ff       <= df_in;
      dsx_ff      <= dsx_in;
      dsz_ff      <= dsz_in;
      l2_ff       <= l2_in;
      len_ff      <= len_in;
      svx_ff      <= svx_in;
      svz_ff      <= svz_in;
      cy_ff       <= cy_in;
      sy_ff       <= sy_in;
      cp_ff       <= cp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // only one shared unit is launched at a time
   a_one_start: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_start, sq_start, dv_start, co_start}))
      else $error("more than one unit launched");

   // an accepted transaction always leaves the idle state
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != fcu_pkg::S_IDLE))
      else $error("accepted transaction not started");

   // a finished frame with a free output register is presented next cycle
   a_present: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fcu_pkg::S_FIN && (!rsp_valid_ff || rsp_tready)) |=> rsp_tvalid)
      else $error("finished frame not presented");

   // a unit never reports completion unless the sequencer waits on it
   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      unit_done |-> busy_ff)
      else $error("unit completion without a launch");

endmodule

[tb/sv/tb_fly_camera_update.sv]
// Self-checking testbench for the fly camera update block.
module tb_fly_camera_update;

   localparam logic CMD_STEP   = 1'b0;
   localparam logic CMD_RELOAD = 1'b1;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   // [0] move_forward, [1] move_back, [2] move_left, [3] move_right,
   // [19:4] yaw_offset, [35:20] pitch_offset, [51:36] step_speed
   logic [55:0]   req_tdata;
   // [0] cmd
   logic [0:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z,
   // [111:96] front_x, [127:112] front_y, [143:128] front_z
   logic [143:0]  rsp_tdata;
   logic          csr_we;
   logic [2:0]    csr_addr;
   logic [31:0]   csr_wdata;

   fly_camera_update i_dut (.*);

   // Camera state mirrored by the predictor.
   logic signed [31:0] cam_pos [3];
   logic signed [15:0] cam_front [3];
   logic [31:0]        cam_yaw, cam_pitch;
   // Start registers.
   logic signed [31:0] st_pos [3];
   logic signed [15:0] st_front [3];
   logic [23:0]        look_sens;
   logic [31:0]        st_yaw;

   logic [143:0] expected_poses [$];
   int           error_count;
   int           send_idle_pct, recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous fixed limit: well over what ~700 items plus stalls need.
   initial begin
      #40000000;
      $display("FAIL fly_camera_update");
      $finish;
   end

   function automatic longint shr_floor(longint v, int n);
      return v >>> n;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint atan_step(int i);
      logic [31:0] t [16];
      t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};
      return longint'(t[i]);
   endfunction

   // Rotate the gain vector by a binary angle; returns cos and sin in Q2.30.
   task automatic rotate(input logic [31:0] a, output longint c, output longint s);
      longint z, x, y, t;
      bit     flip;
      z = longint'(signed'(a));
      x = 652032874;
      y = 0;
      flip = 0;
      if (z >= 64'sh40000000 || z < -64'sh40000000) begin
         flip = 1;
         z = (z >= 0) ? z - 64'sh80000000 : z + 64'sh80000000;
      end
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            t = x - shr_floor(y, i);
            y = y + shr_floor(x, i);
            z = z - atan_step(i);
         end else begin
            t = x + shr_floor(y, i);
            y = y - shr_floor(x, i);
            z = z + atan_step(i);
         end
         x = t;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic longint clamp_unit(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
   endfunction

   function automatic longint unit_div(longint c, logic [63:0] len);
      longint m, q;
      m = (c < 0) ? -c : c;
      q = longint'(((m << 28) + len / 2) / len);
      return (c < 0) ? -q : q;
   endfunction

   task automatic step_along(input longint v [3], input longint spd, input bit neg);
      longint d, p;
      for (int k = 0; k < 3; k++) begin
         d = shr_floor(spd * v[k], 6);
         p = longint'(cam_pos[k]) + (neg ? -d : d);
         if (p > 64'sd2147483647) p = 64'sd2147483647;
         if (p < -64'sd2147483648) p = -64'sd2147483648;
         cam_pos[k] = p[31:0];
      end
   endtask

   task automatic load_start();
      for (int k = 0; k < 3; k++) begin
         cam_pos[k] = st_pos[k];
         cam_front[k] = st_front[k];
      end
      cam_yaw = st_yaw;
      cam_pitch = 0;
   endtask

   // Advance the camera by one transaction and queue the expected pose.
   task automatic predict_pose(input logic cmd, input logic [55:0] d);
      longint fv [3], sv [3];
      longint spd, fx, fz, cy, sy, cp, sp;
      logic [63:0] l2, len;
      if (cmd == CMD_RELOAD) begin
         load_start();
      end else begin
         spd = longint'(signed'(d[51:36]));
         for (int k = 0; k < 3; k++) fv[k] = longint'(cam_front[k]);
         fx = fv[0];
         fz = fv[2];
         if (d[0]) step_along(fv, spd, 0);
         if (d[1]) step_along(fv, spd, 1);
         l2 = 64'(fx * fx) + 64'(fz * fz);
         // Vertical front: no strafe direction, both strafe keys dropped.
         if (l2 != 0) begin
            len = int_sqrt(l2 << 28);
            sv[0] = unit_div(-fz, len);
            sv[1] = 0;
            sv[2] = unit_div(fx, len);
            if (d[3]) step_along(sv, spd, 0);
            if (d[2]) step_along(sv, spd, 1);
         end
         cam_yaw = cam_yaw + 32'(longint'(signed'(d[19:4])) * longint'(look_sens));
         cam_pitch = cam_pitch + 32'(longint'(signed'(d[35:20])) * longint'(look_sens));
         rotate(cam_yaw, cy, sy);
         rotate(cam_pitch, cp, sp);
         cam_front[0] = 16'(clamp_unit(shr_floor(cy * cp + (64'sd1 << 45), 46)));
         cam_front[1] = 16'(clamp_unit(shr_floor(sp + (64'sd1 << 15), 16)));
         cam_front[2] = 16'(clamp_unit(shr_floor(sy * cp + (64'sd1 << 45), 46)));
      end
      expected_poses.push_back({cam_front[2], cam_front[1], cam_front[0],
                                cam_pos[2], cam_pos[1], cam_pos[0]});
   endtask

   // Send one transaction: optional idle gap, then hold valid until taken.
   task automatic send_frame(input logic cmd, input logic [55:0] d);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_pose(cmd, d);
      req_tvalid <= 1'b0;
      // Ready is low for this cycle anyway; keep the drop on its own edge.
      @(posedge clock);
   endtask

   function automatic logic [55:0] frame_data(bit fwd, bit back, bit left, bit right,
                                             logic [15:0] yo, logic [15:0] po,
                                             logic [15:0] spd);
      return {4'd0, spd, po, yo, right, left, back, fwd};
   endfunction

   function automatic logic [55:0] random_frame();
      logic [55:0] d;
      d = 56'({$urandom, $urandom});
      d[55:52] = 4'd0;
      // Keep mouse moves mostly small so the view wanders smoothly.
      if ($urandom_range(3) != 0) begin
         d[19:4]  = 16'($signed($urandom_range(400)) - 200);
         d[35:20] = 16'($signed($urandom_range(400)) - 200);
      end
      return d;
   endfunction

   // Drain outstanding results, then let the block settle before a write.
   task automatic wait_idle();
      while (expected_poses.size() != 0) @(posedge clock);
      repeat (700) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         fcu_pkg::CSR_START_POS_X:   st_pos[0] = v;
         fcu_pkg::CSR_START_POS_Y:   st_pos[1] = v;
         fcu_pkg::CSR_START_POS_Z:   st_pos[2] = v;
         fcu_pkg::CSR_START_FRONT_X: st_front[0] = v[15:0];
         fcu_pkg::CSR_START_FRONT_Y: st_front[1] = v[15:0];
         fcu_pkg::CSR_START_FRONT_Z: st_front[2] = v[15:0];
         fcu_pkg::CSR_LOOK_SENS:     look_sens = v[23:0];
         fcu_pkg::CSR_START_YAW:     st_yaw = v;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Check each result against the oldest expected pose.
   initial begin
      logic [143:0] exp_pose;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_poses.size() == 0) begin
               $error("result with no pending expectation: %h", rsp_tdata);
               error_count++;
            end else begin
               exp_pose = expected_poses.pop_front();
               if (rsp_tdata[31:0] !== exp_pose[31:0]) begin
                  $error("pos_x exp %h got %h", exp_pose[31:0], rsp_tdata[31:0]);
                  error_count++;
               end
               if (rsp_tdata[63:32] !== exp_pose[63:32]) begin
                  $error("pos_y exp %h got %h", exp_pose[63:32], rsp_tdata[63:32]);
                  error_count++;
               end
               if (rsp_tdata[95:64] !== exp_pose[95:64]) begin
                  $error("pos_z exp %h got %h", exp_pose[95:64], rsp_tdata[95:64]);
                  error_count++;
               end
               if (rsp_tdata[111:96] !== exp_pose[111:96]) begin
                  $error("front_x exp %h got %h", exp_pose[111:96], rsp_tdata[111:96]);
                  error_count++;
               end
               if (rsp_tdata[127:112] !== exp_pose[127:112]) begin
                  $error("front_y exp %h got %h", exp_pose[127:112],
                         rsp_tdata[127:112]);
                  error_count++;
               end
               if (rsp_tdata[143:128] !== exp_pose[143:128]) begin
                  $error("front_z exp %h got %h", exp_pose[143:128],
                         rsp_tdata[143:128]);
                  error_count++;
               end
            end
         end
      end
   end

   // Receiver backpressure: drop ready at random at the configured rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Directed: field extremes, every key, reload and the vertical front.
   task automatic test_directed();
      send_frame(CMD_STEP, frame_data(1, 0, 0, 0, 16'h0000, 16'h0000, 16'h0100));
      send_frame(CMD_STEP, frame_data(0, 1, 0, 0, 16'h0001, 16'hFFFF, 16'h7FFF));
      send_frame(CMD_STEP, frame_data(0, 0, 1, 0, 16'h7FFF, 16'h0000, 16'h8000));
      send_frame(CMD_STEP, frame_data(0, 0, 0, 1, 16'h8000, 16'h7FFF, 16'h0080));
      send_frame(CMD_STEP, frame_data(1, 1, 1, 1, 16'hFFFF, 16'h8000, 16'hFFFF));
      send_frame(CMD_RELOAD, 56'hFF_FFFF_FFFF_FFFF);
      // Pitch a quarter turn up to make the front vertical, then strafe.
      wait_idle();
      write_csr(fcu_pkg::CSR_LOOK_SENS, 32'h0040_0000);
      send_frame(CMD_STEP, frame_data(0, 0, 0, 0, 16'h0000, 16'h0100, 16'h0100));
      send_frame(CMD_STEP, frame_data(1, 0, 1, 1, 16'h0000, 16'h0000, 16'h7FFF));
      // Vertical start front loaded directly.
      wait_idle();
      write_csr(fcu_pkg::CSR_START_FRONT_X, 32'h0);
      write_csr(fcu_pkg::CSR_START_FRONT_Y, 32'h4000);
      write_csr(fcu_pkg::CSR_START_FRONT_Z, 32'h0);
      send_frame(CMD_RELOAD, 56'h0);
      send_frame(CMD_STEP, frame_data(1, 1, 1, 1, 16'h0010, 16'h0010, 16'h0200));
      // Saturation at the position extremes with out-of-range front.
      wait_idle();
      write_csr(fcu_pkg::CSR_START_POS_X, 32'h7FFF_FFFF);
      write_csr(fcu_pkg::CSR_START_POS_Y, 32'h8000_0000);
      write_csr(fcu_pkg::CSR_START_POS_Z, 32'h7FFF_0000);
      write_csr(fcu_pkg::CSR_START_FRONT_X, 32'h7FFF);
      write_csr(fcu_pkg::CSR_START_FRONT_Y, 32'h8000);
      write_csr(fcu_pkg::CSR_START_FRONT_Z, 32'hC000);
      write_csr(fcu_pkg::CSR_START_YAW, 32'hFFFF_FFFF);
      write_csr(fcu_pkg::CSR_LOOK_SENS, 32'h00FF_FFFF);
      send_frame(CMD_RELOAD, 56'h0);
      send_frame(CMD_STEP, frame_data(1, 0, 0, 1, 16'h7FFF, 16'h8000, 16'h7FFF));
      send_frame(CMD_STEP, frame_data(0, 1, 1, 0, 16'h8000, 16'h7FFF, 16'h7FFF));
      wait_idle();
      write_csr(fcu_pkg::CSR_LOOK_SENS, 32'h0);
      write_csr(fcu_pkg::CSR_START_YAW, 32'h0);
      send_frame(CMD_RELOAD, 56'h0);
      send_frame(CMD_STEP, frame_data(1, 1, 1, 1, 16'h1234, 16'h4321, 16'h8000));
   endtask

   // Random flight with occasional reloads, under a given idling mix.
   task automatic test_random_flight(input int n, input int s_pct, input int r_pct);
      logic [31:0] v;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      wait_idle();
      // Fresh start registers for this phase.
      for (int i = 0; i < 8; i++) begin
         v = $urandom;
         if (i >= fcu_pkg::CSR_START_FRONT_X && i <= fcu_pkg::CSR_START_FRONT_Z)
            v = 32'($signed($urandom_range(32768)) - 16384);
         if (i == fcu_pkg::CSR_LOOK_SENS) v = $urandom_range(2000000);
         write_csr(i[2:0], v);
      end
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(19) == 0) send_frame(CMD_RELOAD, 56'({$urandom, $urandom}));
         else send_frame(CMD_STEP, random_frame());
      end
   endtask

   initial begin
      error_count   = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      for (int k = 0; k < 3; k++) st_pos[k] = 0;
      st_front = '{16'sd0, 16'sd0, -16'sd16384};
      look_sens = 24'd1193046;
      st_yaw = 32'hC000_0000;
      load_start();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_flight(200, 35, 60);
      test_random_flight(200, 60, 35);
      test_random_flight(200, 0, 0);
      wait_idle();
      if (error_count == 0 && expected_poses.size() == 0) begin
         $display("PASS fly_camera_update");
      end else begin
         $display("FAIL fly_camera_update");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/fcu_pkg.sv
rtl/core/fcu_mul.sv
rtl/core/fcu_sqrt.sv
rtl/core/fcu_div.sv
rtl/core/fcu_cordic.sv
rtl/core/fly_camera_update.sv
tb/sv/tb_fly_camera_update.sv
